// ----- rtl/core/rssb_pkg.sv -----
`default_nettype none

package rssb_pkg;

    localparam int LINE_BYTES_MAX = 4096;
    localparam int ADDRESS_BITS   = 24;

    localparam int OUT_ADDR_W = 24;
    localparam int COUNT_W    = 12;
    localparam int COUNT_CAP  = ((LINE_BYTES_MAX - 1) < 4095) ? (LINE_BYTES_MAX - 1) : 4095;

    localparam int STRIDE_W = 13;
    localparam int ROWS_W   = 8;
    localparam int SCALE_W  = 4;
    localparam int PIXEL_W  = 8;
    localparam int RUN_W    = 7;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [STRIDE_W-1:0]   STRIDE_RST = 13'd640;
    localparam logic [OUT_ADDR_W-1:0] START_RST  = 24'd0;
    localparam logic [ROWS_W-1:0]     ROWS_RST   = 8'd1;
    localparam logic [SCALE_W-1:0]    SCALE_RST  = 4'd1;

    typedef enum logic [1:0] {
        KIND_SPAN   = 2'd0,
        KIND_REWIND = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIDE   = 3'd0,
        CFG_START    = 3'd1,
        CFG_ROWS     = 3'd2,
        CFG_SCALE    = 3'd3,
        CFG_COLORIZE = 3'd4,
        CFG_FILL     = 3'd5,
        CFG_ALPHA    = 3'd6
    } t_cfg_idx;

    // settings that take effect on the next byte
    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic [SCALE_W-1:0]  scale;
        logic                colorize;
        logic [PIXEL_W-1:0]  fill_color;
        logic                alpha_en;
    } t_cfg;

    // reload of the sprite walk, with the values being written
    typedef struct packed {
        logic                  go;
        logic [OUT_ADDR_W-1:0] start_offset;
        logic [ROWS_W-1:0]     row_count;
    } t_restart;

    typedef struct packed {
        t_kind                 kind;
        logic [OUT_ADDR_W-1:0] address;
        logic [PIXEL_W-1:0]    pixel_value;
        logic [SCALE_W-1:0]    span_length;
        logic                  alpha_write;
        logic [COUNT_W-1:0]    rewind_bytes;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/rle_sprite_scaled_blitter_top.sv -----
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------------
// input    | in        | i_valid / o_stall  | i_data_byte
// output   | out       | o_valid / i_stall  | o_kind o_address o_pixel_value o_span_length
//          |           |                    | o_alpha_write o_rewind_bytes
// config   | in        | i_cfg_we           | i_cfg_index i_cfg_data
//
// One byte is taken per cycle while o_stall is low; its request, if any, shows on the output in the next cycle.
// The rate is set by the single output register: a new byte enters while it drains.
// o_stall rises only while a request sits in the output register and i_stall is high.
// Synchronous active-low reset restores register defaults and restarts the sprite.
// A write to start offset or row count restarts the sprite walk.

module rle_sprite_scaled_blitter_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [rssb_pkg::PIXEL_W-1:0]         i_data_byte,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [1:0]                                o_kind,
    output logic [rssb_pkg::OUT_ADDR_W-1:0]           o_address,
    output logic [rssb_pkg::PIXEL_W-1:0]              o_pixel_value,
    output logic [rssb_pkg::SCALE_W-1:0]              o_span_length,
    output logic                                      o_alpha_write,
    output logic [rssb_pkg::COUNT_W-1:0]              o_rewind_bytes,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rssb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rssb_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [rssb_pkg::STRIDE_W-1:0]   r_stride;
    logic [rssb_pkg::OUT_ADDR_W-1:0] r_start;
    logic [rssb_pkg::ROWS_W-1:0]     r_rows;
    logic [rssb_pkg::SCALE_W-1:0]    r_scale;
    logic                            r_colorize;
    logic [rssb_pkg::PIXEL_W-1:0]    r_fill;
    logic                            r_alpha_en;

    rssb_pkg::t_cfg     cfg;
    rssb_pkg::t_restart restart;
    rssb_pkg::t_result  dec_res;
    rssb_pkg::t_result  out_res;
    logic               dec_fire;
    logic               accept;
    logic               out_valid;
    logic               wr_start;
    logic               wr_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride   <= rssb_pkg::STRIDE_RST;
            r_start    <= rssb_pkg::START_RST;
            r_rows     <= rssb_pkg::ROWS_RST;
            r_scale    <= rssb_pkg::SCALE_RST;
            r_colorize <= 1'b0;
            r_fill     <= '0;
            r_alpha_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (rssb_pkg::t_cfg_idx'(i_cfg_index))
                rssb_pkg::CFG_STRIDE:   r_stride   <= i_cfg_data[rssb_pkg::STRIDE_W-1:0];
                rssb_pkg::CFG_START:    r_start    <= i_cfg_data[rssb_pkg::OUT_ADDR_W-1:0];
                rssb_pkg::CFG_ROWS:     r_rows     <= i_cfg_data[rssb_pkg::ROWS_W-1:0];
                rssb_pkg::CFG_SCALE:    r_scale    <= i_cfg_data[rssb_pkg::SCALE_W-1:0];
                rssb_pkg::CFG_COLORIZE: r_colorize <= i_cfg_data[0];
                rssb_pkg::CFG_FILL:     r_fill     <= i_cfg_data[rssb_pkg::PIXEL_W-1:0];
                rssb_pkg::CFG_ALPHA:    r_alpha_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign wr_start = i_cfg_we && (i_cfg_index == rssb_pkg::CFG_START);
    assign wr_rows  = i_cfg_we && (i_cfg_index == rssb_pkg::CFG_ROWS);

    // restart from the value being written, not the stale register
    assign restart.go           = wr_start || wr_rows;
    assign restart.start_offset = wr_start ? i_cfg_data[rssb_pkg::OUT_ADDR_W-1:0] : r_start;
    assign restart.row_count    = wr_rows ? i_cfg_data[rssb_pkg::ROWS_W-1:0] : r_rows;

    assign cfg.stride     = r_stride;
    assign cfg.scale      = r_scale;
    assign cfg.colorize   = r_colorize;
    assign cfg.fill_color = r_fill;
    assign cfg.alpha_en   = r_alpha_en;

    assign o_stall = out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    rssb_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_cfg       (cfg),
        .i_restart   (restart),
        .o_fire      (dec_fire),
        .o_res       (dec_res)
    );

    rssb_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dec_fire),
        .i_res   (dec_res),
        .i_stall (i_stall),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_valid        = out_valid;
    assign o_kind         = out_res.kind;
    assign o_address      = out_res.address;
    assign o_pixel_value  = out_res.pixel_value;
    assign o_span_length  = out_res.span_length;
    assign o_alpha_write  = out_res.alpha_write;
    assign o_rewind_bytes = out_res.rewind_bytes;

endmodule

`default_nettype wire

// ----- rtl/core/rssb_decode.sv -----
`default_nettype none

module rssb_decode (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic [rssb_pkg::PIXEL_W-1:0]         i_data_byte,
    input  wire rssb_pkg::t_cfg                       i_cfg,
    input  wire rssb_pkg::t_restart                   i_restart,
    output logic                                      o_fire,
    output rssb_pkg::t_result                         o_res
);

    localparam int AW = rssb_pkg::ADDRESS_BITS;
    localparam int SW = rssb_pkg::SCALE_W;
    localparam int CW = rssb_pkg::COUNT_W;

    logic [AW-1:0]                 r_line_addr, n_line_addr;
    logic [AW-1:0]                 r_wr_addr,   n_wr_addr;
    logic [rssb_pkg::ROWS_W-1:0]   r_rows_left, n_rows_left;
    logic [SW-1:0]                 r_rep_rows,  n_rep_rows;
    logic [rssb_pkg::RUN_W-1:0]    r_run_left,  n_run_left;
    logic [CW-1:0]                 r_count,     n_count;
    logic                          r_done,      n_done;

    logic [SW-1:0]                 sc;
    logic [CW-1:0]                 count_inc;
    logic [7:0]                    skip;
    logic [11:0]                   skip_len;
    logic [AW-1:0]                 next_line;
    logic [rssb_pkg::ROWS_W-1:0]   rows_dec;
    logic                          active;

    assign sc        = (i_cfg.scale == '0) ? SW'(1) : i_cfg.scale;
    assign count_inc = (r_count < CW'(rssb_pkg::COUNT_CAP)) ? r_count + CW'(1) : r_count;
    assign skip      = 8'd0 - i_data_byte;
    assign skip_len  = {4'd0, skip} * {8'd0, sc};
    assign next_line = r_line_addr + AW'(i_cfg.stride);
    assign rows_dec  = r_rows_left - 8'd1;
    assign active    = i_accept && !r_done && (r_rows_left != '0);

    always_comb begin
        n_line_addr = r_line_addr;
        n_wr_addr   = r_wr_addr;
        n_rows_left = r_rows_left;
        n_rep_rows  = r_rep_rows;
        n_run_left  = r_run_left;
        n_count     = r_count;
        n_done      = r_done;
        o_fire      = 1'b0;
        o_res       = '0;
        if (active) begin
            n_count = count_inc;
            if (r_run_left != '0) begin
                o_fire            = 1'b1;
                o_res.kind        = rssb_pkg::KIND_SPAN;
                o_res.address     = rssb_pkg::OUT_ADDR_W'(r_wr_addr);
                o_res.pixel_value = i_cfg.colorize ? i_cfg.fill_color : i_data_byte;
                o_res.span_length = sc;
                o_res.alpha_write = i_cfg.alpha_en;
                n_wr_addr         = r_wr_addr + AW'(sc);
                n_run_left        = r_run_left - 7'd1;
            end else if (i_data_byte == '0) begin
                n_line_addr = next_line;
                n_wr_addr   = next_line;
                n_count     = '0;
                if (({1'b0, r_rep_rows} + 5'd1) < {1'b0, sc}) begin
                    // ask the source to resend this line for the next copy
                    o_fire             = 1'b1;
                    o_res.kind         = rssb_pkg::KIND_REWIND;
                    o_res.rewind_bytes = count_inc;
                    n_rep_rows         = r_rep_rows + SW'(1);
                end else begin
                    n_rows_left = rows_dec;
                    n_rep_rows  = '0;
                    if (rows_dec == '0) begin
                        o_fire     = 1'b1;
                        o_res.kind = rssb_pkg::KIND_DONE;
                        n_done     = 1'b1;
                    end
                end
            end else if (i_data_byte[7]) begin
                n_wr_addr = r_wr_addr + AW'(skip_len);
            end else begin
                n_run_left = i_data_byte[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_addr <= AW'(rssb_pkg::START_RST);
            r_wr_addr   <= AW'(rssb_pkg::START_RST);
            r_rows_left <= rssb_pkg::ROWS_RST;
            r_rep_rows  <= '0;
            r_run_left  <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
        end else if (i_restart.go) begin
            r_line_addr <= AW'(i_restart.start_offset);
            r_wr_addr   <= AW'(i_restart.start_offset);
            r_rows_left <= i_restart.row_count;
            r_rep_rows  <= '0;
            r_run_left  <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_line_addr <= n_line_addr;
            r_wr_addr   <= n_wr_addr;
            r_rows_left <= n_rows_left;
            r_rep_rows  <= n_rep_rows;
            r_run_left  <= n_run_left;
            r_count     <= n_count;
            r_done      <= n_done;
        end
    end

    a_done_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rows_left == '0))
        else $error("done set while rows remain");

    a_run_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_left != '0) |-> !r_done)
        else $error("literal run pending after sprite done");

    a_rewind_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fire && (o_res.kind == rssb_pkg::KIND_REWIND)) |-> (sc > SW'(1)))
        else $error("rewind request without vertical scaling");

endmodule

`default_nettype wire

// ----- rtl/core/rssb_out_reg.sv -----
`default_nettype none

module rssb_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire rssb_pkg::t_result i_res,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output rssb_pkg::t_result      o_res
);

    logic              r_valid;
    rssb_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload loads only when the slot is free or being drained
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.kind == rssb_pkg::KIND_SPAN))
            |-> ((r_res.span_length != '0) && (r_res.rewind_bytes == '0)))
        else $error("span request with bad length or rewind count");

    a_ctrl_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.kind != rssb_pkg::KIND_SPAN))
            |-> ((r_res.address == '0) && (r_res.pixel_value == '0)
                 && (r_res.span_length == '0) && !r_res.alpha_write))
        else $error("control request carries pixel fields");

endmodule

`default_nettype wire
